// ===== sv/prq_pkg.sv =====
// Shared types, codes and default sizes of the priority ready queue.
package prq_pkg;

    localparam int LEVELS_DEF     = 32;
    localparam int FIFO_DEPTH_DEF = 8;

    localparam int LEVEL_W  = 5;
    localparam int TASK_W   = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 16;

    localparam logic [LEVEL_W-1:0] IDLE_RESET = 5'd31;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH      = 2'd0,
        ACT_POP_NEXT  = 2'd1,
        ACT_POP_LEVEL = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Outcome of one operation as seen by the output stage.
    typedef struct packed {
        logic               took;
        t_status            status;
        logic [LEVEL_W-1:0] top_level;
    } t_step_res;

endpackage

// ===== sv/prq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/prq_ctrl.sv =====
// Per-level head pointers, fill counts and highest-level tracking.
module prq_ctrl #(
    parameter int LEVELS     = prq_pkg::LEVELS_DEF,
    parameter int FIFO_DEPTH = prq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_go,
    input  prq_pkg::t_action                       i_action,
    input  logic [prq_pkg::LEVEL_W-1:0]            i_level,
    input  logic [prq_pkg::TASK_W-1:0]             i_task,
    input  logic [prq_pkg::LEVEL_W-1:0]            i_idle_level,
    output logic                                   o_ram_we,
    output logic                                   o_ram_re,
    output logic [$clog2(LEVELS * FIFO_DEPTH)-1:0] o_ram_addr,
    output logic [prq_pkg::TASK_W-1:0]             o_ram_wdata,
    output prq_pkg::t_step_res                     o_res
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(LEVELS * FIFO_DEPTH);

    logic [PTR_W-1:0]            r_head [LEVELS];
    logic [CNT_W-1:0]            r_fill [LEVELS];
    logic [prq_pkg::LEVEL_W-1:0] r_highest;

    logic [prq_pkg::LEVEL_W-1:0] lv_sel;
    logic                        in_range;
    logic [LVL_W-1:0]            idx;
    logic [PTR_W-1:0]            head_cur;
    logic [CNT_W-1:0]            fill_cur;
    logic [SUM_W-1:0]            tail_sum;
    logic [PTR_W-1:0]            tail;
    logic [PTR_W-1:0]            head_inc;
    logic [LEVELS-1:0]           scan_mask;
    logic [LEVELS-1:0]           first_oh;
    logic [LVL_W-1:0]            first_idx;
    logic [prq_pkg::LEVEL_W-1:0] rescan_level;
    logic                        upd_level;
    logic [PTR_W-1:0]            n_head;
    logic [CNT_W-1:0]            n_fill;
    logic [prq_pkg::LEVEL_W-1:0] n_highest;
    logic                        do_push;
    logic                        do_pop;

    always_comb begin
        lv_sel   = (i_action == prq_pkg::ACT_POP_NEXT) ? r_highest : i_level;
        in_range = 32'(lv_sel) < LEVELS;
        idx      = LVL_W'(lv_sel);
        head_cur = r_head[idx];
        fill_cur = r_fill[idx];

        // Tail slot: head plus occupancy, wrapped once (head < depth, occupancy <= depth).
        tail_sum = SUM_W'(head_cur) + SUM_W'(fill_cur);
        tail     = (32'(tail_sum) >= FIFO_DEPTH) ? PTR_W'(32'(tail_sum) - FIFO_DEPTH)
                                                 : PTR_W'(tail_sum);
        head_inc = (head_cur == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(head_cur + 1'b1);

        // Lowest occupied level once the selected level has drained, capped at the idle level.
        for (int i = 0; i < LEVELS; i++) begin
            scan_mask[i] = (r_fill[i] != '0) && (LVL_W'(i) != idx);
        end
        first_oh  = scan_mask & (~scan_mask + LEVELS'(1));
        first_idx = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (first_oh[i]) begin
                first_idx = first_idx | LVL_W'(i);
            end
        end
        rescan_level = ((|scan_mask) && (32'(first_idx) <= 32'(i_idle_level)))
                     ? prq_pkg::LEVEL_W'(first_idx) : i_idle_level;

        do_push   = 1'b0;
        do_pop    = 1'b0;
        upd_level = 1'b0;
        n_head    = head_cur;
        n_fill    = fill_cur;
        n_highest = r_highest;
        o_res.took   = 1'b0;
        o_res.status = prq_pkg::ST_OK;

        unique case (i_action)
            prq_pkg::ACT_PUSH: begin
                if (!in_range || (fill_cur == CNT_W'(FIFO_DEPTH))) begin
                    o_res.status = prq_pkg::ST_FULL;
                end else begin
                    do_push   = 1'b1;
                    upd_level = 1'b1;
                    n_fill    = CNT_W'(fill_cur + 1'b1);
                    if ((fill_cur == '0) && (lv_sel <= r_highest)) begin
                        n_highest = lv_sel;
                    end
                end
            end
            prq_pkg::ACT_POP_NEXT, prq_pkg::ACT_POP_LEVEL: begin
                if (!in_range || (fill_cur == '0)) begin
                    o_res.status = prq_pkg::ST_EMPTY;
                end else begin
                    do_pop     = 1'b1;
                    upd_level  = 1'b1;
                    o_res.took = 1'b1;
                    n_head     = head_inc;
                    n_fill     = CNT_W'(fill_cur - 1'b1);
                    if ((fill_cur == CNT_W'(1)) && (lv_sel != i_idle_level)
                            && (r_highest == lv_sel)) begin
                        n_highest = rescan_level;
                    end
                end
            end
            default: begin
                o_res.status = prq_pkg::ST_OK;
            end
        endcase

        o_res.top_level = n_highest;
        o_ram_we    = i_go && do_push;
        o_ram_re    = i_go && do_pop;
        o_ram_addr  = ADDR_W'(32'(idx) * FIFO_DEPTH + (do_push ? 32'(tail) : 32'(head_cur)));
        o_ram_wdata = i_task;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
            r_highest <= prq_pkg::IDLE_RESET;
        end else if (i_go) begin
            if (upd_level) begin
                r_head[idx] <= n_head;
                r_fill[idx] <= n_fill;
            end
            r_highest <= n_highest;
        end
    end

endmodule

// ===== sv/priority_ready_queue_top.sv =====
// Top level of the priority ready queue: stream ports, pipeline registers and task RAM.
//
// Ready queue of task identifiers, one FIFO per priority level (lower is more urgent).
// Input stream: each transfer on the s_axis group carries one operation (push a task at
// a level, pop the head of the highest tracked level, or pop the head of a named level).
// Output stream: each operation yields exactly one result transfer on the m_axis group
// with the dequeued task (zero if none), a status code and the tracked highest level.
// The user must write the idle level through i_cfg_we / i_cfg_wdata only while the queue
// is quiet; the block itself does not enforce this.
// The operation is captured in an input register, the level bookkeeping and the task RAM
// access then run in a single pass, and the result register and the RAM's registered
// read port present the outcome. One operation is taken per cycle while the receiver
// takes results, limited by the single-pass update of a level's head and fill count and
// the one RAM port used per operation.
// Reset clears every level to empty, sets the idle level to 31 and the tracked level to
// the same value; the task RAM is not cleared, as only occupied slots are ever read.
// When the receiver stalls, the pending result holds, one further operation may wait in
// the input register, and then o_s_axis_tready drops until the result is taken.
module priority_ready_queue_top #(
    parameter int LEVELS     = prq_pkg::LEVELS_DEF,
    parameter int FIFO_DEPTH = prq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [1:0] action, [6:2] priority_req, [14:7] task_id, [15] zero
    input  logic [prq_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] task_out, [9:8] status, [14:10] top_level, [15] zero
    output logic [prq_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [prq_pkg::LEVEL_W-1:0]   i_cfg_wdata
);

    localparam int RAM_DEPTH = LEVELS * FIFO_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    logic                        r_in_valid;
    prq_pkg::t_action            r_action;
    logic [prq_pkg::LEVEL_W-1:0] r_level;
    logic [prq_pkg::TASK_W-1:0]  r_task;
    logic                        r_out_valid;
    prq_pkg::t_step_res          r_res;
    logic [prq_pkg::LEVEL_W-1:0] r_idle_level;

    logic                        go;
    logic                        in_fire;
    logic                        ram_we;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_addr;
    logic [prq_pkg::TASK_W-1:0]  ram_wdata;
    logic [prq_pkg::TASK_W-1:0]  ram_rdata;
    prq_pkg::t_step_res          step_res;

    // The held operation advances whenever the result register is free or being emptied.
    assign go              = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || go;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idle_level <= prq_pkg::IDLE_RESET;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_idle_level <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= prq_pkg::t_action'(i_s_axis_tdata[1:0]);
            r_level  <= i_s_axis_tdata[6:2];
            r_task   <= i_s_axis_tdata[14:7];
        end
        if (go) begin
            r_res <= step_res;
        end
    end

    prq_ctrl #(
        .LEVELS     (LEVELS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_action     (r_action),
        .i_level      (r_level),
        .i_task       (r_task),
        .i_idle_level (r_idle_level),
        .o_ram_we     (ram_we),
        .o_ram_re     (ram_re),
        .o_ram_addr   (ram_addr),
        .o_ram_wdata  (ram_wdata),
        .o_res        (step_res)
    );

    // Task slots, level-major: level times depth plus slot.
    prq_ram #(
        .WIDTH (prq_pkg::TASK_W),
        .DEPTH (RAM_DEPTH)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // The RAM read data is only meaningful for a pop that dequeued a task.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_res.top_level, r_res.status,
                              (r_res.took ? ram_rdata : {prq_pkg::TASK_W{1'b0}})};

endmodule

// ===== bench/tb_priority_ready_queue_top.sv =====
// Self-checking testbench for the priority ready queue: random and directed operations
// are scored against a behavioural copy of the per-level task FIFOs.
`timescale 1ns / 1ps

module tb_priority_ready_queue_top;

    import prq_pkg::*;

    localparam int                  NUM_LEVELS = LEVELS_DEF;
    localparam int                  DEPTH      = FIFO_DEPTH_DEF;
    // Action code the block does not define; it must leave the queue untouched.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int                  IDLE_PCT   = 38;

    typedef struct packed {
        logic [TASK_W-1:0]  tid;
        t_status            status;
        logic [LEVEL_W-1:0] top;
    } t_outcome;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_axis_tdata;
    logic                 i_cfg_we        = 1'b0;
    logic [LEVEL_W-1:0]   i_cfg_wdata     = '0;

    // Operations waiting to be sent, and outcomes waiting to come back.
    logic [TDATA_W-1:0]   op_q[$];
    t_outcome             outcome_q[$];
    int                   errors = 0;
    // When set, neither side inserts idle cycles.
    bit                   steady = 1'b0;

    // Behavioural state of the queue.
    logic [TASK_W-1:0]    slots [NUM_LEVELS][DEPTH];
    logic [2:0]           head  [NUM_LEVELS];
    logic [3:0]           fill  [NUM_LEVELS];
    logic [LEVEL_W-1:0]   tracked_level;
    logic [LEVEL_W-1:0]   idle_level;

    priority_ready_queue_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Most urgent non-empty level, but never below the idle level in urgency.
    function automatic logic [LEVEL_W-1:0] lowest_ready_level();
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            if (fill[lv] != 0) begin
                return (lv <= idle_level) ? LEVEL_W'(lv) : idle_level;
            end
        end
        return idle_level;
    endfunction

    function automatic logic [TASK_W-1:0] take_head(logic [LEVEL_W-1:0] lv);
        logic [TASK_W-1:0] tid;
        tid      = slots[lv][head[lv]];
        head[lv] = head[lv] + 3'd1;
        fill[lv] = fill[lv] - 4'd1;
        return tid;
    endfunction

    // Applies one operation to the model queue and returns the outcome the block must report.
    // Every 5-bit level exists when there are 32 levels, so no range check is needed.
    function automatic t_outcome apply_operation(logic [TDATA_W-1:0] word);
        logic [ACTION_W-1:0] act;
        logic [LEVEL_W-1:0]  lv;
        logic [LEVEL_W-1:0]  top;
        logic [2:0]          slot;
        t_outcome            res;
        act        = word[1:0];
        lv         = word[6:2];
        res.tid    = '0;
        res.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                if (fill[lv] >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot            = head[lv] + fill[lv][2:0];
                    slots[lv][slot] = word[14:7];
                    fill[lv]        = fill[lv] + 4'd1;
                    if (fill[lv] == 1 && lv <= tracked_level) begin
                        tracked_level = lv;
                    end
                end
            end
            ACT_POP_NEXT: begin
                top = tracked_level;
                if (fill[top] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.tid = take_head(top);
                    if (fill[top] == 0 && top != idle_level) begin
                        tracked_level = lowest_ready_level();
                    end
                end
            end
            ACT_POP_LEVEL: begin
                if (fill[lv] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.tid = take_head(lv);
                    // Only a drained tracked level moves the tracked level.
                    if (fill[lv] == 0 && lv != idle_level && tracked_level == lv) begin
                        tracked_level = lowest_ready_level();
                    end
                end
            end
            default: begin
            end
        endcase
        res.top = tracked_level;
        return res;
    endfunction

    // Sender: offers the next pending operation, idling at random, and records the
    // expected outcome of every transfer it completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                outcome_q.push_back(apply_operation(i_s_axis_tdata));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (op_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_s_axis_tdata  <= op_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks each result transfer against the oldest
    // expected outcome, field by field.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %h", $time, o_m_axis_tdata);
                    errors++;
                end else begin
                    t_outcome want;
                    want = outcome_q.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.tid) begin
                        $display("%0t: task_out expected %0d actual %0d",
                                 $time, want.tid, o_m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (o_m_axis_tdata[9:8] !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_m_axis_tdata[9:8]);
                        errors++;
                    end
                    if (o_m_axis_tdata[14:10] !== want.top) begin
                        $display("%0t: top_level expected %0d actual %0d",
                                 $time, want.top, o_m_axis_tdata[14:10]);
                        errors++;
                    end
                end
            end
            i_m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic add_op(logic [ACTION_W-1:0] act, int lv, logic [TASK_W-1:0] tid);
        op_q.push_back({1'b0, tid, LEVEL_W'(lv), act});
    endtask

    // Waits until nothing is queued, offered or outstanding. Checked on the falling edge so
    // that the sender's updates of the rising edge have all settled.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (op_q.size() != 0 || i_s_axis_tvalid || outcome_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_idle_level(logic [LEVEL_W-1:0] value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        idle_level  = value;
    endtask

    // Random operations clustered on a small window of levels so that FIFOs fill, wrap
    // and drain; the window moves now and then and some items go to any level.
    task automatic add_random_ops(int count, int push_pct);
        int                  base;
        int                  roll;
        int                  lv;
        logic [ACTION_W-1:0] act;
        base = $urandom_range(0, NUM_LEVELS - 4);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 39) begin
                base = $urandom_range(0, NUM_LEVELS - 4);
            end
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                act = ACT_PUSH;
            end else if (roll < push_pct + (95 - push_pct) / 2) begin
                act = ACT_POP_NEXT;
            end else if (roll < 95) begin
                act = ACT_POP_LEVEL;
            end else begin
                act = ACT_UNUSED;
            end
            if ($urandom_range(0, 9) < 7) begin
                lv = base + $urandom_range(0, 3);
            end else begin
                lv = $urandom_range(0, NUM_LEVELS - 1);
            end
            add_op(act, lv, TASK_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int idle_plan[5];
        int push_plan[5];
        idle_plan = '{31, 0, 13, 6, 31};
        push_plan = '{45, 60, 40, 55, 45};
        foreach (head[lv]) begin
            head[lv] = '0;
            fill[lv] = '0;
        end
        idle_level    = IDLE_RESET;
        tracked_level = IDLE_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            write_idle_level(LEVEL_W'(idle_plan[ph]));
            steady = (ph == 3);
            if (ph == 0) begin
                // Extreme levels and identifiers; a push behind the tracked level.
                add_op(ACT_PUSH, 0, 8'hFF);
                add_op(ACT_PUSH, 31, 8'h00);
                add_op(ACT_PUSH, 4, 8'hA5);
                // Draining a level that is not tracked leaves the tracked level alone.
                add_op(ACT_POP_LEVEL, 4, 8'h00);
                // Draining the tracked level rescans; draining the idle level does not.
                add_op(ACT_POP_NEXT, 0, 8'h00);
                add_op(ACT_POP_NEXT, 0, 8'h00);
                add_op(ACT_POP_NEXT, 31, 8'hFF);
                add_op(ACT_POP_LEVEL, 17, 8'h00);
                add_op(ACT_UNUSED, 31, 8'hFF);
                // Fill one level, overflow it, then wrap its pointers and drain it.
                for (int i = 0; i < DEPTH + 1; i++) begin
                    add_op(ACT_PUSH, 9, TASK_W'(8'h10 + i));
                end
                add_op(ACT_POP_LEVEL, 9, 8'h00);
                add_op(ACT_PUSH, 9, 8'h5A);
                for (int i = 0; i < DEPTH; i++) begin
                    add_op(ACT_POP_NEXT, 0, 8'h00);
                end
            end
            add_random_ops(165, push_plan[ph]);
        end

        wait_quiet();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/prq_pkg.sv
sv/prq_ram.sv
sv/prq_ctrl.sv
sv/priority_ready_queue_top.sv
bench/tb_priority_ready_queue_top.sv
